// ----- rtl/interval_union_length_top_defines.svh -----
// Assertion macros used by the top-level file, the only one that asserts.
`ifndef INTERVAL_UNION_LENGTH_TOP_DEFINES_SVH
`define INTERVAL_UNION_LENGTH_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IUL_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define IUL_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/iul_pkg.sv -----
`timescale 1ns / 1ps
package iul_pkg;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ORDER = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic load;       // capture the incoming item
        logic check;      // record a bad-order or full error
        logic rd_prev;    // read entry pos-1
        logic rd_prev2;   // read entry pos-2
        logic wr_shift;   // move read entry up to pos, step pos down
        logic wr_item;    // write held item at pos, bump count
        logic sw_rd;      // read entry at sweep index, advance it
        logic sw_first;   // open the current span from read data
        logic sw_step;    // merge or close against read data
        logic sw_end;     // close the final span
        logic clear_set;  // drop count, sweep index, error, total
    } cmd_t;

    typedef struct packed {
        logic bad_order;
        logic full;
        logic pos_zero;
        logic pos_one;
        logic prev_gt;    // read entry lower above held lower
        logic last;
        logic err_nz;
        logic count_zero;
        logic more;       // sweep index below count
    } sts_t;

endpackage

// ----- rtl/iul_ram.sv -----
`timescale 1ns / 1ps
module iul_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/iul_ctrl.sv -----
`timescale 1ns / 1ps
module iul_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  iul_pkg::sts_t sts,
    output iul_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_CMP, S_PUT, S_FIN, S_SW_FIRST, S_SW_LOOP, S_SW_END, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        s_ready_next = s_ready_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    cmd.load     = 1'b1;
                    s_ready_next = 1'b0;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sts.bad_order || sts.full) begin
                    cmd.check  = 1'b1;
                    state_next = S_FIN;
                end else if (sts.pos_zero) begin
                    cmd.wr_item = 1'b1;
                    state_next  = S_FIN;
                end else begin
                    cmd.rd_prev = 1'b1;
                    state_next  = S_CMP;
                end
            end
            S_CMP: begin
                if (sts.prev_gt) begin
                    cmd.wr_shift = 1'b1;
                    if (sts.pos_one) begin
                        state_next = S_PUT;
                    end else begin
                        cmd.rd_prev2 = 1'b1;
                    end
                end else begin
                    cmd.wr_item = 1'b1;
                    state_next  = S_FIN;
                end
            end
            S_PUT: begin
                cmd.wr_item = 1'b1;
                state_next  = S_FIN;
            end
            S_FIN: begin
                if (!sts.last) begin
                    s_ready_next = 1'b1;
                    state_next   = S_IDLE;
                end else if (sts.err_nz || sts.count_zero) begin
                    m_valid_next = 1'b1;
                    state_next   = S_OUT;
                end else begin
                    cmd.sw_rd  = 1'b1;
                    state_next = S_SW_FIRST;
                end
            end
            S_SW_FIRST: begin
                cmd.sw_first = 1'b1;
                if (sts.more) begin
                    cmd.sw_rd  = 1'b1;
                    state_next = S_SW_LOOP;
                end else begin
                    state_next = S_SW_END;
                end
            end
            S_SW_LOOP: begin
                cmd.sw_step = 1'b1;
                if (sts.more) begin
                    cmd.sw_rd = 1'b1;
                end else begin
                    state_next = S_SW_END;
                end
            end
            S_SW_END: begin
                cmd.sw_end   = 1'b1;
                m_valid_next = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    cmd.clear_set = 1'b1;
                    m_valid_next  = 1'b0;
                    s_ready_next  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next   = S_IDLE;
                s_ready_next = 1'b1;
                m_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            s_ready_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

endmodule

// ----- rtl/iul_datapath.sv -----
`timescale 1ns / 1ps
module iul_datapath #(
    parameter int MAX_INTERVALS = 1024,
    parameter int AW = $clog2(MAX_INTERVALS),
    parameter int CW = $clog2(MAX_INTERVALS + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic signed [31:0]  s_lower_bound,
    input  logic signed [31:0]  s_upper_bound,
    input  logic                s_last_interval,
    input  iul_pkg::cmd_t       cmd,
    output iul_pkg::sts_t       sts,
    output logic                ram_wr_en,
    output logic [AW-1:0]       ram_wr_addr,
    output logic [63:0]         ram_wr_data,
    output logic [AW-1:0]       ram_rd_addr,
    input  logic [63:0]         ram_rd_data,
    output logic [31:0]         m_total_length,
    output logic [1:0]          m_status
);

    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_INTERVALS);

    logic signed [31:0] lo_reg, hi_reg;
    logic               last_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic [CW-1:0]      rd_idx_reg, rd_idx_next;
    logic [1:0]         err_reg, err_next;
    logic [32:0]        total_reg, total_next;
    logic signed [32:0] cur_lo_reg, cur_lo_next, cur_hi_reg, cur_hi_next;
    logic signed [32:0] rd_lo, rd_hi;
    logic [CW-1:0]      pos_m1, pos_m2;
    logic [32:0]        span;

    assign rd_lo  = {ram_rd_data[63], ram_rd_data[63:32]};
    assign rd_hi  = {ram_rd_data[31], ram_rd_data[31:0]};
    assign pos_m1 = pos_reg - CW'(1);
    assign pos_m2 = pos_reg - CW'(2);
    assign span   = 33'(cur_hi_reg - cur_lo_reg);

    always_comb begin
        ram_wr_en   = cmd.wr_shift || cmd.wr_item;
        ram_wr_addr = pos_reg[AW-1:0];
        ram_wr_data = cmd.wr_shift ? ram_rd_data : {lo_reg, hi_reg};
        if (cmd.rd_prev) begin
            ram_rd_addr = pos_m1[AW-1:0];
        end else if (cmd.rd_prev2) begin
            ram_rd_addr = pos_m2[AW-1:0];
        end else begin
            ram_rd_addr = rd_idx_reg[AW-1:0];
        end
    end

    always_comb begin
        count_next  = count_reg;
        pos_next    = pos_reg;
        rd_idx_next = rd_idx_reg;
        err_next    = err_reg;
        total_next  = total_reg;
        cur_lo_next = cur_lo_reg;
        cur_hi_next = cur_hi_reg;
        if (cmd.load) begin
            pos_next = count_reg;
        end
        if (cmd.check && err_reg == iul_pkg::ST_OK) begin
            err_next = (lo_reg > hi_reg) ? iul_pkg::ST_ORDER : iul_pkg::ST_FULL;
        end
        if (cmd.wr_shift) begin
            pos_next = pos_m1;
        end
        if (cmd.wr_item) begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.sw_rd) begin
            rd_idx_next = rd_idx_reg + CW'(1);
        end
        if (cmd.sw_first) begin
            cur_lo_next = rd_lo;
            cur_hi_next = rd_hi;
        end
        if (cmd.sw_step) begin
            if (rd_lo > cur_hi_reg) begin
                total_next  = total_reg + span;
                cur_lo_next = rd_lo;
                cur_hi_next = rd_hi;
            end else if (rd_hi > cur_hi_reg) begin
                cur_hi_next = rd_hi;
            end
        end
        if (cmd.sw_end) begin
            total_next = total_reg + span;
        end
        if (cmd.clear_set) begin
            count_next  = '0;
            rd_idx_next = '0;
            err_next    = iul_pkg::ST_OK;
            total_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            rd_idx_reg <= '0;
            err_reg    <= iul_pkg::ST_OK;
            total_reg  <= '0;
        end else begin
            count_reg  <= count_next;
            rd_idx_reg <= rd_idx_next;
            err_reg    <= err_next;
            total_reg  <= total_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            lo_reg   <= s_lower_bound;
            hi_reg   <= s_upper_bound;
            last_reg <= s_last_interval;
        end
        pos_reg    <= pos_next;
        cur_lo_reg <= cur_lo_next;
        cur_hi_reg <= cur_hi_next;
    end

    always_comb begin
        sts.bad_order  = lo_reg > hi_reg;
        sts.full       = count_reg >= MAX_COUNT;
        sts.pos_zero   = pos_reg == '0;
        sts.pos_one    = pos_reg == CW'(1);
        sts.prev_gt    = $signed(ram_rd_data[63:32]) > lo_reg;
        sts.last       = last_reg;
        sts.err_nz     = err_reg != iul_pkg::ST_OK;
        sts.count_zero = count_reg == '0;
        sts.more       = rd_idx_reg < count_reg;
    end

    assign m_total_length = total_reg[31:0];
    assign m_status       = err_reg;

endmodule

// ----- rtl/interval_union_length_top.sv -----
`timescale 1ns / 1ps
// Union length of one-dimensional closed intervals.
// Input channel (s_*): one interval per transfer, signed lower and upper
// bounds plus s_last_interval marking the final interval of a set.
// Result channel (m_*): one transfer per set, issued after the last
// interval, with the union length and a status (ok, lower above upper,
// too many intervals). The length is zero whenever the status is not ok.
// Insertion: an interval is inserted in sorted order into a store with one
// read port by shifting entries with a greater lower bound up one per
// cycle; a dropped interval, or one with no greater entry, needs no shifting.
// s_ready stays low until the item is placed, so no new interval is taken
// meanwhile. After the last item, unless the set failed or is empty, the
// sweep reads the store once, one entry per cycle, before m_valid rises.
// The store's single read port limits both insertion and sweep.
// Reset: the set is emptied and the error cleared; the store needs no
// clearing pass since only entries below the count are ever used.
// Stall: while m_ready is low the result holds and no new interval is
// taken; after the result transfer a new set begins.
`include "interval_union_length_top_defines.svh"

module interval_union_length_top #(
    parameter int MAX_INTERVALS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_lower_bound,
    input  logic [31:0] s_upper_bound,
    input  logic        s_last_interval,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_total_length,
    output logic [1:0]  m_status
);

    localparam int AW = $clog2(MAX_INTERVALS);
    localparam int CW = $clog2(MAX_INTERVALS + 1);

    iul_pkg::cmd_t cmd;
    iul_pkg::sts_t sts;

    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [63:0]   ram_wr_data;
    logic [AW-1:0] ram_rd_addr;
    logic [63:0]   ram_rd_data;

    // Sequence load, insert, sweep and result handshakes.
    iul_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Hold the item, count, error and sweep accumulator.
    iul_datapath #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .AW            (AW),
        .CW            (CW)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_lower_bound   (s_lower_bound),
        .s_upper_bound   (s_upper_bound),
        .s_last_interval (s_last_interval),
        .cmd             (cmd),
        .sts             (sts),
        .ram_wr_en       (ram_wr_en),
        .ram_wr_addr     (ram_wr_addr),
        .ram_wr_data     (ram_wr_data),
        .ram_rd_addr     (ram_rd_addr),
        .ram_rd_data     (ram_rd_data),
        .m_total_length  (m_total_length),
        .m_status        (m_status)
    );

    // Sorted interval store: lower bound in the upper half of each word.
    iul_ram #(
        .WIDTH (64),
        .DEPTH (MAX_INTERVALS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Never take an interval while a result is pending.
    `IUL_ASSERT_NOW(a_no_overlap, m_valid, !s_ready, "input ready while result pending")
    // A failed set reports zero length.
    `IUL_ASSERT_NOW(a_err_zero, m_valid && m_status != iul_pkg::ST_OK, m_total_length == '0, "length on error")
    // Status code stays within its defined range.
    `IUL_ASSERT_NOW(a_status_range, m_valid, m_status <= iul_pkg::ST_FULL, "undefined status code")
    // After the result transfer, input opens for a new set.
    `IUL_ASSERT_NEXT(a_reopen, m_valid && m_ready, s_ready && !m_valid, "input not reopened")

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

    localparam int STORE_DEPTH = 1024;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 560;

    // Scoreboard: mirrors the sorted interval store and computes the union
    // length for each finished set, then checks results in order.
    class union_scoreboard;
        int          depth;
        int          lower_q[$];
        int          upper_q[$];
        logic [1:0]  set_error;
        logic [31:0] length_due[$];
        logic [1:0]  status_due[$];
        int          failures;

        function new(int store_depth);
            depth = store_depth;
            set_error = iul_pkg::ST_OK;
            failures = 0;
        endfunction

        // Sweep the sorted intervals; touching or overlapping spans merge.
        function logic [31:0] union_length();
            longint total;
            longint span_lo;
            longint span_hi;
            total = 0;
            if (lower_q.size() == 0)
                return 0;
            span_lo = lower_q[0];
            span_hi = upper_q[0];
            for (int i = 1; i < lower_q.size(); i++) begin
                if (longint'(lower_q[i]) > span_hi) begin
                    total += span_hi - span_lo;
                    span_lo = lower_q[i];
                    span_hi = upper_q[i];
                end else if (longint'(upper_q[i]) > span_hi) begin
                    span_hi = upper_q[i];
                end
            end
            total += span_hi - span_lo;
            return total[31:0];
        endfunction

        function void note_interval(int lower, int upper, bit last);
            int pos;
            if (lower > upper) begin
                if (set_error == iul_pkg::ST_OK) set_error = iul_pkg::ST_ORDER;
            end else if (lower_q.size() >= depth) begin
                if (set_error == iul_pkg::ST_OK) set_error = iul_pkg::ST_FULL;
            end else begin
                // equal lower bounds keep arrival order
                pos = lower_q.size();
                while (pos > 0 && lower_q[pos-1] > lower) pos--;
                lower_q.insert(pos, lower);
                upper_q.insert(pos, upper);
            end
            if (!last)
                return;
            status_due.push_back(set_error);
            length_due.push_back(set_error == iul_pkg::ST_OK ? union_length() : 32'd0);
            lower_q.delete();
            upper_q.delete();
            set_error = iul_pkg::ST_OK;
        endfunction

        function void check_result(logic [31:0] length, logic [1:0] status);
            logic [31:0] want_length;
            logic [1:0]  want_status;
            if (status_due.size() == 0) begin
                $error("unexpected result: total_length %0d status %0d", length, status);
                failures++;
                return;
            end
            want_length = length_due.pop_front();
            want_status = status_due.pop_front();
            if (length !== want_length) begin
                $error("total_length: expected %0d, actual %0d", want_length, length);
                failures++;
            end
            if (status !== want_status) begin
                $error("status: expected %0d, actual %0d", want_status, status);
                failures++;
            end
        endfunction

        function int pending();
            return status_due.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_lower_bound;
    logic [31:0] s_upper_bound;
    logic        s_last_interval;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_total_length;
    logic [1:0]  m_status;

    union_scoreboard sb;
    bit idle_on;
    int items_sent;
    int cycle_count;

    interval_union_length_top #(
        .MAX_INTERVALS(STORE_DEPTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_lower_bound(s_lower_bound),
        .s_upper_bound(s_upper_bound),
        .s_last_interval(s_last_interval),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_total_length(m_total_length),
        .m_status(m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: end the run as failed once the cycle count exceeds CYCLE_LIMIT.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Result monitor: sample each result transfer at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_total_length, m_status);
    end

    // Receiver: alternate ready runs with stall bursts while idling is on.
    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (idle_on && $urandom_range(0, 2) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
                repeat ($urandom_range(1, 20) - 1) @(negedge aclk);
            end
        end
    end

    // Drive one interval and hold it until the transfer completes.
    task automatic send_interval(int lower, int upper, bit last);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_valid         = 1'b1;
        s_lower_bound   = lower;
        s_upper_bound   = upper;
        s_last_interval = last;
        do @(posedge aclk); while (!s_ready);
        sb.note_interval(lower, upper, last);
        items_sent++;
        @(negedge aclk);
    endtask

    // Pick a bound: full range, a tight cluster for overlaps, or an extreme.
    function automatic int pick_bound(int style, int base);
        case (style)
            0: return $urandom;
            1: return base + int'($urandom_range(0, 300));
            default: return $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                                 : 32'h7fff_ffff - $urandom_range(0, 3);
        endcase
    endfunction

    task automatic random_set(int count);
        int style;
        int base;
        int a;
        int b;
        int t;
        style = $urandom_range(0, 9) < 6 ? 1 : ($urandom_range(0, 3) == 0 ? 2 : 0);
        base = $urandom;
        for (int k = 0; k < count; k++) begin
            a = pick_bound($urandom_range(0, 7) == 0 ? 0 : style, base);
            b = pick_bound($urandom_range(0, 7) == 0 ? 0 : style, base);
            if ($urandom_range(0, 19) == 0) begin
                // broken interval: lower strictly above upper
                if (a < b) begin t = a; a = b; b = t; end
                if (a == b) begin a = 5; b = 3; end
            end else if (a > b) begin
                t = a; a = b; b = t;
            end
            send_interval(a, b, k == count - 1);
        end
    endtask

    // Fill the store in ascending order so every insertion is cheap.
    task automatic fill_store();
        int lower;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            lower = i * 8 - 4000;
            send_interval(lower, lower + $urandom_range(0, 12), 1'b0);
        end
    endtask

    initial begin
        bit paused;
        sb = new(STORE_DEPTH);
        idle_on = 1'b1;
        items_sent = 0;
        paused = 1'b0;
        s_valid = 1'b0;
        s_lower_bound = '0;
        s_upper_bound = '0;
        s_last_interval = 1'b0;
        aresetn = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Widest interval: the union length reaches 2^32 - 1.
        send_interval(32'h8000_0000, 32'h7fff_ffff, 1'b1);
        // Point interval has zero length.
        send_interval(5, 5, 1'b1);
        // Nested, touching, equal-lower and disjoint spans in one set.
        send_interval(0, 10, 1'b0);
        send_interval(5, 7, 1'b0);
        send_interval(10, 20, 1'b0);
        send_interval(-3, -1, 1'b0);
        send_interval(0, 2, 1'b1);
        // Bad order first, then good: the error still stands.
        send_interval(9, 1, 1'b0);
        send_interval(1, 9, 1'b1);
        // Bad order on the last item itself.
        send_interval(-8, 8, 1'b0);
        send_interval(32'h7fff_ffff, 32'h8000_0000, 1'b1);
        // A lone bad interval.
        send_interval(0, -1, 1'b1);

        // Full store, overflow first, then a last item that is both full
        // and out of order: status stays full.
        fill_store();
        send_interval(7, 9, 1'b0);
        send_interval(100, 50, 1'b1);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (!paused && items_sent > RANDOM_ITEMS / 2) begin
                // hold off until every expected result has drained
                paused = 1'b1;
                s_valid = 1'b0;
                while (sb.pending() != 0) @(posedge aclk);
                @(negedge aclk);
            end
            if (items_sent > RANDOM_ITEMS * 7 / 8)
                idle_on = 1'b0;
            random_set($urandom_range(0, 9) == 0 ? $urandom_range(13, 40)
                                                 : $urandom_range(1, 12));
        end
        s_valid = 1'b0;
        idle_on = 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
